// ----- rtl/edsp_pkg.sv -----
// shared types, constants and the group order table for the der signature parser
`default_nettype none

package edsp_pkg;

    // scalar size in bytes by default, and the fixed output framing
    localparam int SCALAR_BYTES_DEF = 32;
    localparam int GROUP_BYTES      = 32;
    localparam int WORD_BITS        = 32;
    localparam int WORDS_OUT        = 16;
    localparam int RAM_DEPTH_DEF    = 32;

    // length register width and the guard for long-form lengths
    localparam int LR_W      = 56;
    localparam int LR_GUARD  = 48;

    // der codes
    localparam logic [7:0] TAG_SEQ       = 8'h30;
    localparam logic [7:0] TAG_INT       = 8'h02;
    localparam logic [7:0] LEN_LONG_FORM = 8'h80;

    localparam logic [3:0] WORD_LAST = 4'(WORDS_OUT - 1);

    // secp256k1 group order, most significant byte first
    localparam logic [7:0] GROUP_ORDER [GROUP_BYTES] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
        8'hBA, 8'hAE, 8'hDC, 8'hE6, 8'hAF, 8'h48, 8'hA0, 8'h3B,
        8'hBF, 8'hD2, 8'h5E, 8'h8C, 8'hD0, 8'h36, 8'h41, 8'h41
    };

    // parser phases
    typedef enum logic [11:0] {
        PH_SEQ_TAG  = 12'b0000_0000_0001,
        PH_SEQ_LEN  = 12'b0000_0000_0010,
        PH_SEQ_SKIP = 12'b0000_0000_0100,
        PH_R_TAG    = 12'b0000_0000_1000,
        PH_R_LEN    = 12'b0000_0001_0000,
        PH_R_LONG   = 12'b0000_0010_0000,
        PH_R_VAL    = 12'b0000_0100_0000,
        PH_S_TAG    = 12'b0000_1000_0000,
        PH_S_LEN    = 12'b0001_0000_0000,
        PH_S_LONG   = 12'b0010_0000_0000,
        PH_S_VAL    = 12'b0100_0000_0000,
        PH_DONE     = 12'b1000_0000_0000
    } t_phase;

    // running comparison against the group order
    typedef enum logic [1:0] {
        CMP_EQUAL   = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2
    } t_cmp;

    // end-of-signature status handed from the parser to the emitter
    typedef struct packed {
        logic valid;
        logic bank;
        logic parse_ok;
        logic value_ovf;
    } t_done;

    // one result word
    typedef struct packed {
        logic                 parse_ok;
        logic                 range_overflow;
        logic [WORD_BITS-1:0] sig_word;
        logic [3:0]           word_index;
        logic                 last_word;
    } t_result;

    // order byte lined up with scalar byte p, zero outside the table
    function automatic logic [7:0] order_byte(input logic [6:0] p, input int sb);
        int off;
        off = int'(p) + GROUP_BYTES - sb;
        if (off < 0 || off >= GROUP_BYTES) begin
            return 8'h00;
        end
        return GROUP_ORDER[off[4:0]];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/edsp_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module edsp_ram import edsp_pkg::*; #(
    parameter  int WIDTH = WORD_BITS,
    parameter  int DEPTH = RAM_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/edsp_parser.sv -----
// der structure walker, group order compare and word-combining writes into the buffer ram
`default_nettype none

module edsp_parser import edsp_pkg::*; #(
    parameter  int SCALAR_BYTES = SCALAR_BYTES_DEF,
    localparam int NUM_WORDS    = (2 * SCALAR_BYTES + 3) / 4,
    localparam int WA_W         = $clog2(NUM_WORDS),
    localparam int POS_W        = $clog2(2 * SCALAR_BYTES),
    localparam int P_W          = $clog2(SCALAR_BYTES + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_last,
    input  wire logic [1:0]           i_bank_full,
    output      logic                 o_ready,
    output      logic                 o_we,
    output      logic                 o_wr_bank,
    output      logic [WA_W-1:0]      o_wr_wa,
    output      logic [WORD_BITS-1:0] o_wr_data,
    output      t_done                o_done
);

    // parse state
    t_phase                r_phase, n_phase;
    logic [LR_W-1:0]       r_lr, n_lr;
    logic [6:0]            r_lbl, n_lbl;
    logic                  r_strip, n_strip;
    logic                  r_failed, n_failed;
    logic                  r_ovf, n_ovf;
    t_cmp                  r_cmp, n_cmp;
    logic                  r_wb;

    // word being assembled
    logic                  r_hold_v;
    logic [WA_W-1:0]       r_hold_wa;
    logic [WORD_BITS-1:0]  r_hold_word;

    logic                  accept;
    logic                  take;
    logic                  is_s;
    logic                  start;
    logic [LR_W-1:0]       start_len;
    logic                  fin;
    logic                  wr_cond;
    logic                  ovf_w;
    t_cmp                  cmp_w;
    logic [LR_W-1:0]       lr_dec;
    logic [LR_W-1:0]       lr_shift;
    logic [P_W-1:0]        lr_low;
    logic [P_W-1:0]        p;
    logic [POS_W-1:0]      pos;
    logic [WA_W-1:0]       wa;
    logic [1:0]            lane;
    logic [7:0]            ob;
    logic [WORD_BITS-1:0]  base_word;
    logic [WORD_BITS-1:0]  merged;

    assign o_ready = !i_bank_full[r_wb];
    assign accept  = i_valid && o_ready;
    assign take    = !r_failed && (r_phase != PH_DONE);
    assign is_s    = (r_phase == PH_S_LEN) || (r_phase == PH_S_LONG) || (r_phase == PH_S_VAL);

    // byte position inside the r||s buffer
    assign lr_dec   = r_lr - LR_W'(1);
    assign lr_shift = {r_lr[LR_W-9:0], i_byte};
    assign lr_low   = r_lr[P_W-1:0];
    assign p        = P_W'(SCALAR_BYTES) - lr_low;
    assign pos      = (is_s ? POS_W'(SCALAR_BYTES) : POS_W'(0)) + POS_W'(p);
    assign wa       = WA_W'(pos >> 2);
    assign lane     = pos[1:0];
    assign ob       = order_byte(7'(p), SCALAR_BYTES);

    // merge the new byte into the held word, big-endian lanes
    assign base_word = (r_hold_v && (r_hold_wa == wa)) ? r_hold_word : '0;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            merged[WORD_BITS-1-8*k -: 8] = (lane == 2'(k)) ? i_byte
                                                           : base_word[WORD_BITS-1-8*k -: 8];
        end
    end

    // next parse state for one byte
    always_comb begin
        n_phase   = r_phase;
        n_lr      = r_lr;
        n_lbl     = r_lbl;
        n_strip   = r_strip;
        n_failed  = r_failed;
        n_ovf     = r_ovf;
        n_cmp     = r_cmp;
        start     = 1'b0;
        start_len = '0;
        fin       = 1'b0;
        wr_cond   = 1'b0;
        ovf_w     = r_ovf;
        cmp_w     = r_cmp;
        if (take) begin
            case (r_phase)
                PH_SEQ_TAG: begin
                    if (i_byte != TAG_SEQ) n_failed = 1'b1;
                    else n_phase = PH_SEQ_LEN;
                end
                PH_SEQ_LEN: begin
                    if (((i_byte & LEN_LONG_FORM) != 8'h00) && (i_byte[6:0] != 7'd0)) begin
                        n_lbl   = i_byte[6:0];
                        n_phase = PH_SEQ_SKIP;
                    end else begin
                        n_phase = PH_R_TAG;
                    end
                end
                PH_SEQ_SKIP: begin
                    n_lbl = r_lbl - 7'd1;
                    if (r_lbl == 7'd1) n_phase = PH_R_TAG;
                end
                PH_R_TAG: begin
                    if (i_byte != TAG_INT) n_failed = 1'b1;
                    else n_phase = PH_R_LEN;
                end
                PH_S_TAG: begin
                    if (i_byte != TAG_INT) n_failed = 1'b1;
                    else n_phase = PH_S_LEN;
                end
                PH_R_LEN, PH_S_LEN: begin
                    if ((i_byte & LEN_LONG_FORM) != 8'h00) begin
                        n_lr = '0;
                        if (i_byte[6:0] == 7'd0) begin
                            start = 1'b1;
                        end else begin
                            n_lbl   = i_byte[6:0];
                            n_phase = is_s ? PH_S_LONG : PH_R_LONG;
                        end
                    end else begin
                        start     = 1'b1;
                        start_len = LR_W'(i_byte);
                    end
                end
                PH_R_LONG, PH_S_LONG: begin
                    if (r_lr[LR_W-1:LR_GUARD] != '0) begin
                        n_failed = 1'b1;
                    end else begin
                        n_lr  = lr_shift;
                        n_lbl = r_lbl - 7'd1;
                        if (r_lbl == 7'd1) begin
                            start     = 1'b1;
                            start_len = lr_shift;
                        end
                    end
                end
                PH_R_VAL, PH_S_VAL: begin
                    if (r_strip && (i_byte == 8'h00)) begin
                        n_lr = lr_dec;
                    end else begin
                        // first significant byte fixes the length and order prefix
                        if (r_strip) begin
                            n_strip = 1'b0;
                            if (r_lr > LR_W'(SCALAR_BYTES)) begin
                                ovf_w = 1'b1;
                            end else if ((SCALAR_BYTES >= GROUP_BYTES) && (cmp_w == CMP_EQUAL)
                                         && (int'(lr_low) < GROUP_BYTES)) begin
                                cmp_w = CMP_LESS;
                            end
                        end
                        if (!ovf_w) begin
                            wr_cond = 1'b1;
                            if (cmp_w == CMP_EQUAL) begin
                                if (i_byte < ob) cmp_w = CMP_LESS;
                                else if (i_byte > ob) cmp_w = CMP_GREATER;
                            end
                        end
                        n_lr  = lr_dec;
                        n_ovf = ovf_w;
                        n_cmp = cmp_w;
                    end
                    if (lr_dec == '0) fin = 1'b1;
                end
                default: begin
                end
            endcase

            // open an integer of known length
            if (start) begin
                n_lr    = start_len;
                n_strip = 1'b1;
                n_cmp   = (SCALAR_BYTES < GROUP_BYTES) ? CMP_LESS : CMP_EQUAL;
                n_phase = is_s ? PH_S_VAL : PH_R_VAL;
                if (start_len == '0) fin = 1'b1;
            end

            // close an integer and check it against the order
            if (fin) begin
                if (!n_strip && (n_cmp != CMP_LESS)) n_ovf = 1'b1;
                n_phase = is_s ? PH_DONE : PH_S_TAG;
            end
        end
    end

    // buffer write port
    assign o_we      = accept && wr_cond;
    assign o_wr_bank = r_wb;
    assign o_wr_wa   = wa;
    assign o_wr_data = merged;

    // signature status on the last byte
    assign o_done.valid     = accept && i_last;
    assign o_done.bank      = r_wb;
    assign o_done.parse_ok  = !n_failed && (n_phase == PH_DONE);
    assign o_done.value_ovf = n_ovf;

    // state update, back to the start after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEQ_TAG;
            r_lr     <= '0;
            r_lbl    <= '0;
            r_strip  <= 1'b1;
            r_failed <= 1'b0;
            r_ovf    <= 1'b0;
            r_cmp    <= CMP_EQUAL;
            r_wb     <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_phase  <= PH_SEQ_TAG;
                r_lr     <= '0;
                r_lbl    <= '0;
                r_strip  <= 1'b1;
                r_failed <= 1'b0;
                r_ovf    <= 1'b0;
                r_cmp    <= CMP_EQUAL;
                r_wb     <= ~r_wb;
                r_hold_v <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_lr     <= n_lr;
                r_lbl    <= n_lbl;
                r_strip  <= n_strip;
                r_failed <= n_failed;
                r_ovf    <= n_ovf;
                r_cmp    <= n_cmp;
                if (wr_cond) begin
                    r_hold_v <= 1'b1;
                end
            end
        end
    end

    // held word follows every buffer write
    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_hold_wa   <= wa;
            r_hold_word <= merged;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/edsp_emit.sv -----
// bank bookkeeping, buffer read-out and the output register with skid stage
`default_nettype none

module edsp_emit import edsp_pkg::*; #(
    parameter  int SCALAR_BYTES = SCALAR_BYTES_DEF,
    localparam int NUM_WORDS    = (2 * SCALAR_BYTES + 3) / 4,
    localparam int WA_W         = $clog2(NUM_WORDS)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_done                i_done,
    input  wire logic                 i_we,
    input  wire logic                 i_wr_bank,
    input  wire logic [WA_W-1:0]      i_wr_wa,
    output      logic [1:0]           o_bank_full,
    output      logic [WA_W:0]        o_raddr,
    input  wire logic [WORD_BITS-1:0] i_rdata,
    output      logic                 o_valid,
    input  wire logic                 i_ready,
    output      t_result              o_result
);

    // per-bank state
    logic [1:0]           r_full, n_full;
    logic [1:0]           r_ok;
    logic [1:0]           r_ovf;
    logic [NUM_WORDS-1:0] r_wvld [2];
    logic [NUM_WORDS-1:0] n_wvld [2];
    logic                 r_eb;
    logic [3:0]           r_w;

    // read stage
    logic                 r_rd_v;
    logic [3:0]           r_rd_w;
    logic                 r_rd_ok;
    logic                 r_rd_ovf;
    logic                 r_rd_keep;

    // output register and skid
    logic                 r_out_v;
    t_result              r_out;
    logic                 r_skid_v;
    t_result              r_skid;

    logic                 xfer;
    logic [1:0]           occ;
    logic                 issue;
    logic                 wrap;
    logic [WA_W-1:0]      e_wa;
    logic                 in_range;
    logic                 keep;
    t_result              rd_res;

    assign xfer  = r_out_v && i_ready;
    assign occ   = 2'(r_rd_v) + 2'(r_out_v) + 2'(r_skid_v);
    assign issue = r_full[r_eb] && ((occ < 2'd2) || ((occ == 2'd2) && xfer));
    assign wrap  = issue && (r_w == WORD_LAST);

    // word address and its masking
    assign e_wa     = WA_W'(r_w);
    assign in_range = int'(r_w) < NUM_WORDS;
    assign keep     = in_range && r_wvld[r_eb][e_wa] && r_ok[r_eb] && !r_ovf[r_eb];
    assign o_raddr  = {r_eb, e_wa};

    // result built from the ram data
    always_comb begin
        rd_res.parse_ok       = r_rd_ok;
        rd_res.range_overflow = r_rd_ok && r_rd_ovf;
        rd_res.sig_word       = r_rd_keep ? i_rdata : '0;
        rd_res.word_index     = r_rd_w;
        rd_res.last_word      = (r_rd_w == WORD_LAST);
    end

    // next bank full and word valid flags
    always_comb begin
        n_full = r_full;
        n_wvld = r_wvld;
        if (i_done.valid) begin
            n_full[i_done.bank] = 1'b1;
        end
        if (wrap) begin
            n_full[r_eb] = 1'b0;
            n_wvld[r_eb] = '0;
        end
        if (i_we) begin
            n_wvld[i_wr_bank][i_wr_wa] = 1'b1;
        end
    end

    assign o_bank_full = r_full;
    assign o_valid     = r_out_v;
    assign o_result    = r_out;

    // bank flags, read issue and output staging
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= '0;
            r_eb     <= 1'b0;
            r_w      <= '0;
            r_wvld   <= '{default: '0};
            r_rd_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_full <= n_full;
            r_wvld <= n_wvld;
            if (i_done.valid) begin
                r_ok[i_done.bank]  <= i_done.parse_ok;
                r_ovf[i_done.bank] <= i_done.value_ovf;
            end

            r_rd_v <= issue;
            if (issue) begin
                r_rd_w    <= r_w;
                r_rd_ok   <= r_ok[r_eb];
                r_rd_ovf  <= r_ovf[r_eb];
                r_rd_keep <= keep;
                r_w       <= r_w + 4'd1;
            end
            if (wrap) begin
                r_eb <= ~r_eb;
            end

            if (xfer || !r_out_v) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_out_v  <= 1'b1;
                    r_skid_v <= r_rd_v;
                    r_skid   <= rd_res;
                end else begin
                    r_out_v <= r_rd_v;
                    r_out   <= rd_res;
                end
            end else if (r_rd_v) begin
                r_skid_v <= 1'b1;
                r_skid   <= rd_res;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ecdsa_der_signature_lax_parser.sv -----
// top level of the lax der ecdsa signature parser
//
// channel   dir  tdata                                 tuser                     tlast
// s_axis    in   [7:0] signature byte                  -                         last byte
// m_axis    out  [31:0] r||s word, [35:32] word index  [0] parse ok, [1] range   sixteenth word
//
// one signature byte is taken per cycle; the parser state and the compare step run once a byte
// each signature gives sixteen words from a ping-pong buffer ram, one per cycle if the sink is ready
// first word: bank full flag, ram read, output register; input stalls only while both banks are full
// (a signature shorter than about sixteen bytes arriving while the previous one still drains)
// synchronous active-low reset; word valid flags clear at once, so there is no ram clearing pass
// output register plus skid stage keeps reads flowing when the sink stalls
`default_nettype none

module ecdsa_der_signature_lax_parser import edsp_pkg::*; #(
    parameter  int SCALAR_BYTES = SCALAR_BYTES_DEF,
    localparam int NUM_WORDS    = (2 * SCALAR_BYTES + 3) / 4,
    localparam int WA_W         = $clog2(NUM_WORDS),
    localparam int RAM_DEPTH    = 2 << WA_W
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic        i_s_axis_tlast,
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [39:0] o_m_axis_tdata,   // [31:0] sig_word, [35:32] word_index, rest zero
    output      logic [1:0]  o_m_axis_tuser,   // [0] parse_ok, [1] range_overflow
    output      logic        o_m_axis_tlast
);

    logic                 we;
    logic                 wr_bank;
    logic [WA_W-1:0]      wr_wa;
    logic [WORD_BITS-1:0] wr_data;
    logic [WA_W:0]        raddr;
    logic [WORD_BITS-1:0] rdata;
    logic [1:0]           bank_full;
    t_done                done;
    t_result              result;

    // byte parser
    edsp_parser #(
        .SCALAR_BYTES(SCALAR_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_bank_full (bank_full),
        .o_ready     (o_s_axis_tready),
        .o_we        (we),
        .o_wr_bank   (wr_bank),
        .o_wr_wa     (wr_wa),
        .o_wr_data   (wr_data),
        .o_done      (done)
    );

    // r||s buffer, two banks
    edsp_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr ({wr_bank, wr_wa}),
        .i_wdata (wr_data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // word read-out
    edsp_emit #(
        .SCALAR_BYTES(SCALAR_BYTES)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_done      (done),
        .i_we        (we),
        .i_wr_bank   (wr_bank),
        .i_wr_wa     (wr_wa),
        .o_bank_full (bank_full),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (result)
    );

    // output packing
    assign o_m_axis_tdata = {4'b0000, result.word_index, result.sig_word};
    assign o_m_axis_tuser = {result.range_overflow, result.parse_ok};
    assign o_m_axis_tlast = result.last_word;

endmodule

`default_nettype wire

// ----- rtl/edsp_checker.sv -----
// port-level checks for the der signature parser, bound to the top level
`default_nettype none

module edsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [7:0]  i_s_axis_tdata,
    input wire logic        i_s_axis_tlast,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);

    // a stalled result transfer holds its word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // tlast marks exactly the sixteenth word
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[35:32] == 4'hF)))
        else $error("tlast out of step with word index");

    // range flag only on a structurally accepted signature
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tuser[0])
        else $error("range flag without parse ok");

    // failed or out-of-range signatures give zero words
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (!o_m_axis_tuser[0] || o_m_axis_tuser[1])
        |-> (o_m_axis_tdata[31:0] == 32'h0000_0000))
        else $error("non-zero word on a rejected signature");

endmodule

bind ecdsa_der_signature_lax_parser edsp_checker u_edsp_checker (.*);

`default_nettype wire
